>>> rtl/qrm_pkg.sv
package qrm_pkg;

    // field widths
    localparam int DATA_W   = 16;
    localparam int THR_W    = 16;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;
    // squared length: sum of four squares of up to 2^30 each, unsigned
    localparam int N_W      = 33;
    // signed numerators: widest is twice a sum of two signed products
    localparam int NUM_W    = 34;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ENTRIES  = 9;

    localparam int OUT_FRAC_DEFAULT = 14;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

    // register map, word index
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_word;

endpackage

>>> rtl/quaternion_to_rotation_matrix.sv
// Channel   Direction  Handshake               Word
// -------   ---------  ----------------------  ------------------------------
// input     in         start & !busy           i_qx i_qy i_qz i_qw (Q3.12)
// result    out        o_valid, one cycle      o_m00..o_m22 (Q1.14), o_degenerate
// config    in/out     psel & penable (APB)    degenerate_threshold at 0x0
//
// One quaternion may enter every cycle; busy is never raised.
// The pipeline is: input register,
// multipliers, sums, one restoring-divider stage per quotient bit, output.
// Nine dividers run side by side, one per matrix entry.
// Synchronous active-low reset clears valid bits and sets the threshold to 17.
// Results cannot be held off; a result shows on the ports for one cycle.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [DATA_W-1:0]  i_qx,
    input  logic signed [DATA_W-1:0]  i_qy,
    input  logic signed [DATA_W-1:0]  i_qz,
    input  logic signed [DATA_W-1:0]  i_qw,
    output logic                      o_valid,
    output logic signed [DATA_W-1:0]  o_m00,
    output logic signed [DATA_W-1:0]  o_m01,
    output logic signed [DATA_W-1:0]  o_m02,
    output logic signed [DATA_W-1:0]  o_m10,
    output logic signed [DATA_W-1:0]  o_m11,
    output logic signed [DATA_W-1:0]  o_m12,
    output logic signed [DATA_W-1:0]  o_m20,
    output logic signed [DATA_W-1:0]  o_m21,
    output logic signed [DATA_W-1:0]  o_m22,
    output logic                      o_degenerate,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [APB_W-1:0]          pwdata,
    output logic [APB_W-1:0]          prdata,
    output logic                      pready
);

    // quotient bits: integer bit, F fraction bits, one rounding bit
    localparam int QW  = OUT_FRAC_BITS + 2;
    localparam int SW  = QW + DATA_W + 1;
    localparam int LAT = QW + 4;
    localparam logic signed [DATA_W-1:0] ONE =
        (OUT_FRAC_BITS >= DATA_W - 1) ? DATA_W'(32'sd32767)
                                      : DATA_W'(32'sd1 <<< OUT_FRAC_BITS);
    localparam logic [SW-1:0] POS_MAX = SW'(32767);
    localparam logic [SW-1:0] NEG_MAX = SW'(32768);

    // configuration register
    logic [THR_W-1:0] r_thr;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready
                  & (t_reg_idx'(paddr[2]) == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (cfg_wr) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (t_reg_idx'(paddr[2]) == REG_THRESHOLD) begin
            prdata = {{(APB_W-THR_W){1'b0}}, r_thr};
        end
    end

    assign busy = 1'b0;

    // stage 1: input register
    logic                     r_v1;
    logic signed [DATA_W-1:0] r_x, r_y, r_z, r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_qx;
        r_y <= i_qy;
        r_z <= i_qz;
        r_w <= i_qw;
    end

    // stage 2: ten products
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_zz, r_ww;
    logic signed [PROD_W-1:0] r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_zz <= r_z * r_z;
        r_ww <= r_w * r_w;
        r_xy <= r_x * r_y;
        r_xz <= r_x * r_z;
        r_yz <= r_y * r_z;
        r_wx <= r_w * r_x;
        r_wy <= r_w * r_y;
        r_wz <= r_w * r_z;
    end

    // stage 3: squared length, numerators, sign split
    logic signed [NUM_W-1:0] e_xx, e_yy, e_zz, e_ww;
    logic signed [NUM_W-1:0] e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [NUM_W-1:0] num [ENTRIES];
    logic        [N_W-1:0]   n_sum;
    logic                    r_v3;
    logic                    r_deg3;
    logic        [N_W-1:0]   r_n3;
    logic        [N_W-1:0]   r_mag3 [ENTRIES];
    logic                    r_neg3 [ENTRIES];

    always_comb begin
        e_xx = NUM_W'(r_xx);
        e_yy = NUM_W'(r_yy);
        e_zz = NUM_W'(r_zz);
        e_ww = NUM_W'(r_ww);
        e_xy = NUM_W'(r_xy);
        e_xz = NUM_W'(r_xz);
        e_yz = NUM_W'(r_yz);
        e_wx = NUM_W'(r_wx);
        e_wy = NUM_W'(r_wy);
        e_wz = NUM_W'(r_wz);
        n_sum  = N_W'(e_xx + e_yy + e_zz + e_ww);
        num[0] = e_ww + e_xx - e_yy - e_zz;
        num[1] = (e_xy + e_wz) <<< 1;
        num[2] = (e_xz - e_wy) <<< 1;
        num[3] = (e_xy - e_wz) <<< 1;
        num[4] = e_ww - e_xx + e_yy - e_zz;
        num[5] = (e_yz + e_wx) <<< 1;
        num[6] = (e_xz + e_wy) <<< 1;
        num[7] = (e_yz - e_wx) <<< 1;
        num[8] = e_ww - e_xx - e_yy + e_zz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n3   <= n_sum;
        r_deg3 <= (n_sum <= {{(N_W-THR_W){1'b0}}, r_thr});
        for (int e = 0; e < ENTRIES; e++) begin
            r_neg3[e] <= num[e][NUM_W-1];
            r_mag3[e] <= num[e][NUM_W-1] ? N_W'(-num[e]) : N_W'(num[e]);
        end
    end

    // divider stages: one quotient bit per stage, magnitude never above n
    logic           r_dv   [QW];
    logic           r_ddeg [QW];
    logic [N_W-1:0] r_dn   [QW];
    logic [N_W-1:0] r_rem  [QW][ENTRIES];
    logic [QW-1:0]  r_q    [QW][ENTRIES];
    logic           r_dneg [QW][ENTRIES];

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic           v_in;
        logic           deg_in;
        logic [N_W-1:0] n_in;
        logic [N_W:0]   trial  [ENTRIES];
        logic [QW-1:0]  q_in   [ENTRIES];
        logic           neg_in [ENTRIES];
        logic [N_W:0]   diff   [ENTRIES];
        logic           bit_q  [ENTRIES];

        if (s == 0) begin : g_first
            assign v_in   = r_v3;
            assign deg_in = r_deg3;
            assign n_in   = r_n3;
            always_comb begin
                for (int e = 0; e < ENTRIES; e++) begin
                    trial[e]  = {1'b0, r_mag3[e]};
                    q_in[e]   = '0;
                    neg_in[e] = r_neg3[e];
                end
            end
        end else begin : g_next
            assign v_in   = r_dv[s-1];
            assign deg_in = r_ddeg[s-1];
            assign n_in   = r_dn[s-1];
            always_comb begin
                for (int e = 0; e < ENTRIES; e++) begin
                    trial[e]  = {r_rem[s-1][e], 1'b0};
                    q_in[e]   = r_q[s-1][e];
                    neg_in[e] = r_dneg[s-1][e];
                end
            end
        end

        always_comb begin
            for (int e = 0; e < ENTRIES; e++) begin
                diff[e]  = trial[e] - {1'b0, n_in};
                bit_q[e] = ~diff[e][N_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else begin
                r_dv[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ddeg[s] <= deg_in;
            r_dn[s]   <= n_in;
            for (int e = 0; e < ENTRIES; e++) begin
                r_rem[s][e]  <= bit_q[e] ? diff[e][N_W-1:0] : trial[e][N_W-1:0];
                r_dneg[s][e] <= neg_in[e];
                r_q[s][e]    <= {q_in[e][QW-2:0], bit_q[e]};
            end
        end
    end

    // output stage: round half away from zero, saturate, identity override
    logic [SW-1:0] q_rnd [ENTRIES];
    t_word         ent   [ENTRIES];
    logic          r_ov;
    logic          r_odeg;
    t_word         r_m   [ENTRIES];

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            q_rnd[e] = (SW'(r_q[QW-1][e]) + SW'(1)) >> 1;
            if (r_dneg[QW-1][e]) begin
                ent[e] = (q_rnd[e] > NEG_MAX) ? DATA_W'(32'sh8000)
                                              : DATA_W'(-q_rnd[e]);
            end else begin
                ent[e] = (q_rnd[e] > POS_MAX) ? DATA_W'(32'sd32767)
                                              : DATA_W'(q_rnd[e]);
            end
            if (r_ddeg[QW-1]) begin
                ent[e] = (e == 0 || e == 4 || e == 8) ? ONE : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_odeg <= r_ddeg[QW-1];
        for (int e = 0; e < ENTRIES; e++) begin
            r_m[e] <= ent[e];
        end
    end

    assign o_valid      = r_ov;
    assign o_degenerate = r_odeg;
    assign o_m00 = r_m[0];
    assign o_m01 = r_m[1];
    assign o_m02 = r_m[2];
    assign o_m10 = r_m[3];
    assign o_m11 = r_m[4];
    assign o_m12 = r_m[5];
    assign o_m20 = r_m[6];
    assign o_m21 = r_m[7];
    assign o_m22 = r_m[8];

`ifndef NO_ASSERTIONS
    // every accepted word comes out after the fixed latency
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after accepted word");

    // no result without an earlier accepted word
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    // degenerate result is the identity
    a_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_m00 == ONE && o_m11 == ONE && o_m22 == ONE &&
         o_m01 == '0 && o_m02 == '0 && o_m10 == '0 &&
         o_m12 == '0 && o_m20 == '0 && o_m21 == '0))
        else $error("degenerate result is not identity");

    // reset empties the pipeline
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");
`endif

endmodule
